// ===== design/nnis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared types and constants for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

	// default parameter values
	localparam int TEX_DIM_DEF = 256;
	localparam int OUT_DIM_DEF = 1024;

	// field widths
	localparam int TEXEL_W   = 24;
	localparam int SRC_REG_W = 9;
	localparam int DST_REG_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int COORD_W   = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

	// input opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ROW,
		ST_DIV_ROW,
		ST_MUL_BASE,
		ST_MUL_COL,
		ST_DIV_COL,
		ST_ADDR,
		ST_READ,
		ST_OUT
	} state_t;

endpackage

// ===== design/nearest_neighbor_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Nearest-neighbor resize of a stored texture onto a destination raster,
// with one shared multiplier and a restoring divider under a sequencer.
// ----------------------------------------------------------------------------
//
// channel | handshake           | payload
// --------+---------------------+-------------------------------------------
// in      | in_valid / in_ready | op, texel_in
// out     | out_valid/out_ready | pixel_out, dst_col, dst_row, frame_end
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// A load request is written when it is accepted, and the block stays ready.
// An emit request holds in_ready low while the sequencer runs; the divider
// makes one quotient bit per cycle for the row and then the column, and
// the multiplier is shared by the row product, row base address and column
// product. Reset sets all sizes to 1 and the load and raster counters to
// zero; the texel store is not cleared and needs no clearing pass.
// A result waits in the output register while out_ready is low; an emit that
// finishes while that register is still full holds in its last step.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler #(
	parameter int TEX_DIM = nnis_pkg::TEX_DIM_DEF,
	parameter int OUT_DIM = nnis_pkg::OUT_DIM_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input requests
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [nnis_pkg::TEXEL_W-1:0]      texel_in,
	// output requests
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nnis_pkg::TEXEL_W-1:0]      pixel_out,
	output logic [nnis_pkg::COORD_W-1:0]      dst_col,
	output logic [nnis_pkg::COORD_W-1:0]      dst_row,
	output logic                              frame_end,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nnis_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// derived widths
	localparam int DEPTH = TEX_DIM * TEX_DIM;
	localparam int AAW   = $clog2(DEPTH);
	localparam int TW    = $clog2(DEPTH + 1);
	localparam int SW    = $clog2(TEX_DIM + 1);
	localparam int DW    = $clog2(OUT_DIM + 1);
	localparam int QW    = $clog2(TEX_DIM);
	localparam int CW    = $clog2(OUT_DIM);
	localparam int AW    = (CW > QW) ? CW : QW;
	localparam int PW    = AW + SW;
	localparam int NW    = $clog2(QW + 1);
	localparam int SXW   = (SW > nnis_pkg::SRC_REG_W) ? SW : nnis_pkg::SRC_REG_W;
	localparam int DXW   = (DW > nnis_pkg::DST_REG_W) ? DW : nnis_pkg::DST_REG_W;
	localparam int OXW   = (CW > nnis_pkg::COORD_W) ? CW : nnis_pkg::COORD_W;

	nnis_pkg::state_t st_q, st_d;

	// clamped size registers
	logic [SW-1:0] sw_q, sh_q;
	logic [DW-1:0] dw_q, dh_q;

	// counters
	logic [AAW-1:0] load_idx_q;
	logic [CW-1:0]  out_col_q, out_row_q;

	// working registers of one emit
	logic [CW-1:0]  wcol_q, wrow_q;
	logic           last_q;
	logic [DW-1:0]  rem_q;
	logic [QW-1:0]  dvd_q;
	logic [NW-1:0]  cnt_q;
	logic [AAW-1:0] base_q, addr_q;
	logic [nnis_pkg::TEXEL_W-1:0] rd_q;

	// output register
	logic                         out_valid_q;
	logic [nnis_pkg::TEXEL_W-1:0] pixel_q;
	logic [nnis_pkg::COORD_W-1:0] col_out_q, row_out_q;
	logic                         fend_q;

	// texel store
	logic [nnis_pkg::TEXEL_W-1:0] texel_mem_q [DEPTH];

	logic in_acc, load_acc, emit_acc, cfg_acc, out_free, div_last;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && (op == nnis_pkg::OP_LOAD);
	assign emit_acc  = in_acc && (op == nnis_pkg::OP_EMIT);
	assign out_free  = !out_valid_q || out_ready;
	assign div_last  = (cnt_q == '0);

	// size clamping for configuration writes
	logic [SXW-1:0] src_x, src_c;
	logic [DXW-1:0] dst_x, dst_c;

	always_comb begin
		src_x = SXW'(cfg_data[nnis_pkg::SRC_REG_W-1:0]);
		if (src_x == '0) begin
			src_c = SXW'(1);
		end else if (src_x > SXW'(TEX_DIM)) begin
			src_c = SXW'(TEX_DIM);
		end else begin
			src_c = src_x;
		end
		dst_x = DXW'(cfg_data[nnis_pkg::DST_REG_W-1:0]);
		if (dst_x == '0) begin
			dst_c = DXW'(1);
		end else if (dst_x > DXW'(OUT_DIM)) begin
			dst_c = DXW'(OUT_DIM);
		end else begin
			dst_c = dst_x;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SW'(1);
			sh_q <= SW'(1);
			dw_q <= DW'(1);
			dh_q <= DW'(1);
		end else if (cfg_acc) begin
			unique case (cfg_index)
				nnis_pkg::CFG_SRC_WIDTH:  sw_q <= SW'(src_c);
				nnis_pkg::CFG_SRC_HEIGHT: sh_q <= SW'(src_c);
				nnis_pkg::CFG_DST_WIDTH:  dw_q <= DW'(dst_c);
				nnis_pkg::CFG_DST_HEIGHT: dh_q <= DW'(dst_c);
				default: ;
			endcase
		end
	end

	// load address with wrap at the texel count
	logic [TW-1:0]  total;
	logic [AAW-1:0] ld_eff;
	logic [TW-1:0]  ld_nxt;

	always_comb begin
		total  = TW'(sw_q) * TW'(sh_q);
		ld_eff = (TW'(load_idx_q) >= total) ? '0 : load_idx_q;
		ld_nxt = TW'(ld_eff) + TW'(1);
	end

	// raster position with wrap at the destination size
	logic [CW-1:0] col_eff, row_eff;
	logic          last_col, last_pix;

	always_comb begin
		col_eff  = (DW'(out_col_q) >= dw_q) ? '0 : out_col_q;
		row_eff  = (DW'(out_row_q) >= dh_q) ? '0 : out_row_q;
		last_col = (DW'(col_eff) == dw_q - DW'(1));
		last_pix = last_col && (DW'(row_eff) == dh_q - DW'(1));
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else begin
			if (load_acc) begin
				load_idx_q <= (ld_nxt >= total) ? '0 : AAW'(ld_nxt);
			end
			if (emit_acc) begin
				if (last_col) begin
					out_col_q <= '0;
					out_row_q <= last_pix ? '0 : row_eff + CW'(1);
				end else begin
					out_col_q <= col_eff + CW'(1);
					out_row_q <= row_eff;
				end
			end
		end
	end

	// shared multiplier
	logic [AW-1:0] mul_a;
	logic [SW-1:0] mul_b;
	logic [PW-1:0] prod;

	always_comb begin
		case (st_q)
			nnis_pkg::ST_MUL_BASE: begin
				mul_a = AW'(dvd_q);
				mul_b = sw_q;
			end
			nnis_pkg::ST_MUL_COL: begin
				mul_a = AW'(wcol_q);
				mul_b = sw_q;
			end
			default: begin
				mul_a = AW'(wrow_q);
				mul_b = sh_q;
			end
		endcase
		prod = PW'(mul_a) * PW'(mul_b);
	end

	// shared restoring divider step, one quotient bit per cycle
	logic [DW-1:0] divisor;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          ge;

	always_comb begin
		divisor = (st_q == nnis_pkg::ST_DIV_COL) ? dw_q : dh_q;
		trial   = {rem_q, dvd_q[QW-1]};
		diff    = {1'b0, trial} - {2'b00, divisor};
		ge      = !diff[DW+1];
	end

	// datapath of one emit
	always_ff @(posedge clk) begin
		if (emit_acc) begin
			wcol_q <= col_eff;
			wrow_q <= row_eff;
			last_q <= last_pix;
		end
		case (st_q)
			nnis_pkg::ST_MUL_ROW, nnis_pkg::ST_MUL_COL: begin
				rem_q <= DW'(prod >> QW);
				dvd_q <= prod[QW-1:0];
				cnt_q <= NW'(QW - 1);
			end
			nnis_pkg::ST_DIV_ROW, nnis_pkg::ST_DIV_COL: begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dvd_q <= QW'({dvd_q, ge});
				cnt_q <= cnt_q - NW'(1);
			end
			nnis_pkg::ST_MUL_BASE: begin
				base_q <= AAW'(prod);
			end
			nnis_pkg::ST_ADDR: begin
				addr_q <= base_q + AAW'(dvd_q);
			end
			default: ;
		endcase
	end

	// texel store write and registered read
	always_ff @(posedge clk) begin
		if (load_acc) begin
			texel_mem_q[ld_eff] <= texel_in;
		end
		rd_q <= texel_mem_q[addr_q];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= nnis_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// sequencer next state
	always_comb begin
		st_d     = st_q;
		in_ready = 1'b0;
		unique case (st_q)
			nnis_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (emit_acc) begin
					st_d = nnis_pkg::ST_MUL_ROW;
				end
			end
			nnis_pkg::ST_MUL_ROW:  st_d = nnis_pkg::ST_DIV_ROW;
			nnis_pkg::ST_DIV_ROW: begin
				if (div_last) begin
					st_d = nnis_pkg::ST_MUL_BASE;
				end
			end
			nnis_pkg::ST_MUL_BASE: st_d = nnis_pkg::ST_MUL_COL;
			nnis_pkg::ST_MUL_COL:  st_d = nnis_pkg::ST_DIV_COL;
			nnis_pkg::ST_DIV_COL: begin
				if (div_last) begin
					st_d = nnis_pkg::ST_ADDR;
				end
			end
			nnis_pkg::ST_ADDR:     st_d = nnis_pkg::ST_READ;
			nnis_pkg::ST_READ:     st_d = nnis_pkg::ST_OUT;
			nnis_pkg::ST_OUT: begin
				if (out_free) begin
					st_d = nnis_pkg::ST_IDLE;
				end
			end
			default: st_d = nnis_pkg::ST_IDLE;
		endcase
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == nnis_pkg::ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	logic [OXW-1:0] col_x, row_x;

	always_comb begin
		col_x = OXW'(wcol_q);
		row_x = OXW'(wrow_q);
	end

	always_ff @(posedge clk) begin
		if ((st_q == nnis_pkg::ST_OUT) && out_free) begin
			pixel_q   <= rd_q;
			col_out_q <= col_x[nnis_pkg::COORD_W-1:0];
			row_out_q <= row_x[nnis_pkg::COORD_W-1:0];
			fend_q    <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_q;
	assign dst_col   = col_out_q;
	assign dst_row   = row_out_q;
	assign frame_end = fend_q;

`ifndef SYNTHESIS
	// load counter stays inside the texture
	a_load_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(load_acc && !cfg_acc) |=> (TW'(load_idx_q) < total))
		else $error("load index beyond texel count");

	// raster counters stay inside the destination frame
	a_raster: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_acc && !cfg_acc) |=> ((DW'(out_col_q) < dw_q) && (DW'(out_row_q) < dh_q)))
		else $error("raster counter beyond destination size");

	// finishing an emit fills the output register with its frame flag
	a_out_fill: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == nnis_pkg::ST_OUT) && out_free) |=> (out_valid_q && (fend_q == $past(last_q))))
		else $error("emit result not loaded into output register");
`endif

endmodule

// ===== bench/tb_nearest_neighbor_image_scaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_image_scaler
// Self-checking bench for the nearest-neighbor image scaler. A short table of
// directed requests covers size clamping, load and raster wrap and counter
// restarts after a size change. Random phases then reprogram the sizes, load
// a texture and emit pixels. Every pixel is checked against an in-bench
// resampling model, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_image_scaler;

	localparam int TEX_DIM      = nnis_pkg::TEX_DIM_DEF;
	localparam int OUT_DIM      = nnis_pkg::OUT_DIM_DEF;
	localparam int STORE_DEPTH  = TEX_DIM * TEX_DIM;
	localparam int EMIT_LATENCY = 2 * $clog2(TEX_DIM) + 7;
	localparam int DRAIN_CYCLES = EMIT_LATENCY + 8;
	localparam int RANDOM_ITEMS = 650;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 3000;

	// one destination pixel as the block reports it
	typedef struct packed {
		logic [nnis_pkg::TEXEL_W-1:0] pixel;
		logic [nnis_pkg::COORD_W-1:0] col;
		logic [nnis_pkg::COORD_W-1:0] row;
		logic                         fe;
	} pixel_result_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// one line of the directed table
	typedef struct packed {
		row_kind_t                       kind;
		logic [nnis_pkg::CFG_IDX_W-1:0]  idx;
		logic [nnis_pkg::CFG_DATA_W-1:0] data;
		logic                            op;
		logic [nnis_pkg::TEXEL_W-1:0]    texel;
		logic                            typed;
		pixel_result_t                   want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [nnis_pkg::TEXEL_W-1:0] texel_in;
	logic out_valid;
	logic out_ready;
	logic [nnis_pkg::TEXEL_W-1:0] pixel_out;
	logic [nnis_pkg::COORD_W-1:0] dst_col;
	logic [nnis_pkg::COORD_W-1:0] dst_row;
	logic frame_end;
	logic cfg_valid;
	logic cfg_ready;
	logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [nnis_pkg::CFG_DATA_W-1:0] cfg_data;

	// resampling model state
	logic [nnis_pkg::TEXEL_W-1:0]   texture_mem [STORE_DEPTH];
	bit                             written_map [STORE_DEPTH];
	int unsigned                    load_ptr;
	int unsigned                    raster_col;
	int unsigned                    raster_row;
	logic [nnis_pkg::SRC_REG_W-1:0] src_w_reg;
	logic [nnis_pkg::SRC_REG_W-1:0] src_h_reg;
	logic [nnis_pkg::DST_REG_W-1:0] dst_w_reg;
	logic [nnis_pkg::DST_REG_W-1:0] dst_h_reg;

	pixel_result_t pending_pixels [$];
	stim_row_t     directed_rows [$];
	int            mismatches;
	int            stall_count;
	bit            calm;
	bit            hold_request;
	bit            hold_served;

	nearest_neighbor_image_scaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.texel_in  (texel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.dst_col   (dst_col),
		.dst_row   (dst_row),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// zero and over-range sizes clamp into 1..limit
	function automatic int unsigned fit_size(int unsigned raw, int unsigned limit);
		if (raw == 0)
			return 1;
		if (raw > limit)
			return limit;
		return raw;
	endfunction

	// store address the next emit request will fetch
	function automatic int unsigned next_fetch_addr();
		int unsigned sw, sh, dw, dh, c, r;
		sw = fit_size(32'(src_w_reg), TEX_DIM);
		sh = fit_size(32'(src_h_reg), TEX_DIM);
		dw = fit_size(32'(dst_w_reg), OUT_DIM);
		dh = fit_size(32'(dst_h_reg), OUT_DIM);
		c = (raster_col >= dw) ? 0 : raster_col;
		r = (raster_row >= dh) ? 0 : raster_row;
		return ((r * sh) / dh) * sw + (c * sw) / dw;
	endfunction

	task automatic reset_model();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			texture_mem[i] = '0;
			written_map[i] = 1'b0;
		end
		load_ptr   = 0;
		raster_col = 0;
		raster_row = 0;
		src_w_reg  = nnis_pkg::SRC_REG_W'(1);
		src_h_reg  = nnis_pkg::SRC_REG_W'(1);
		dst_w_reg  = nnis_pkg::DST_REG_W'(1);
		dst_h_reg  = nnis_pkg::DST_REG_W'(1);
	endtask

	task automatic apply_reg_write(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
			input logic [nnis_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			nnis_pkg::CFG_SRC_WIDTH: begin
				src_w_reg = data[nnis_pkg::SRC_REG_W-1:0];
			end
			nnis_pkg::CFG_SRC_HEIGHT: begin
				src_h_reg = data[nnis_pkg::SRC_REG_W-1:0];
			end
			nnis_pkg::CFG_DST_WIDTH: begin
				dst_w_reg = data[nnis_pkg::DST_REG_W-1:0];
			end
			default: begin
				dst_h_reg = data[nnis_pkg::DST_REG_W-1:0];
			end
		endcase
	endtask

	// advance the model by one accepted request
	task automatic apply_request(input logic o, input logic [nnis_pkg::TEXEL_W-1:0] t,
			output bit has_px, output pixel_result_t px);
		int unsigned sw, sh, dw, dh, total, addr;
		bit last_col;
		sw = fit_size(32'(src_w_reg), TEX_DIM);
		sh = fit_size(32'(src_h_reg), TEX_DIM);
		dw = fit_size(32'(dst_w_reg), OUT_DIM);
		dh = fit_size(32'(dst_h_reg), OUT_DIM);
		total = sw * sh;
		has_px = 1'b0;
		px = '0;
		if (o == nnis_pkg::OP_LOAD) begin
			if (load_ptr >= total)
				load_ptr = 0;
			texture_mem[load_ptr] = t;
			written_map[load_ptr] = 1'b1;
			load_ptr++;
			if (load_ptr >= total)
				load_ptr = 0;
			return;
		end
		if (raster_col >= dw)
			raster_col = 0;
		if (raster_row >= dh)
			raster_row = 0;
		addr = ((raster_row * sh) / dh) * sw + (raster_col * sw) / dw;
		last_col = (raster_col == dw - 1);
		has_px = 1'b1;
		px.pixel = texture_mem[addr];
		px.col = nnis_pkg::COORD_W'(raster_col);
		px.row = nnis_pkg::COORD_W'(raster_row);
		px.fe = last_col && (raster_row == dh - 1);
		if (last_col) begin
			raster_col = 0;
			raster_row = px.fe ? 0 : raster_row + 1;
		end else begin
			raster_col++;
		end
	endtask

	// wait for every pixel and let any request still in flight finish
	task automatic drain_block();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_reg(input logic [nnis_pkg::CFG_IDX_W-1:0] idx,
			input logic [nnis_pkg::CFG_DATA_W-1:0] data);
		if (in_valid)
			in_valid <= 1'b0;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg_write(idx, data);
	endtask

	// offer one request, with random idling before it
	task automatic send_request(input logic o, input logic [nnis_pkg::TEXEL_W-1:0] t,
			input bit typed, input pixel_result_t want);
		bit has_px;
		pixel_result_t px;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 35);
		end
		in_valid <= 1'b1;
		op       <= o;
		texel_in <= t;
		do @(posedge clk); while (!in_ready);
		apply_request(o, t, has_px, px);
		if (has_px)
			pending_pixels.push_back(typed ? want : px);
	endtask

	function automatic stim_row_t cfg_row(logic [nnis_pkg::CFG_IDX_W-1:0] idx,
			logic [nnis_pkg::CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic o, logic [nnis_pkg::TEXEL_W-1:0] t);
		stim_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.op = o;
		r.texel = t;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic o, logic [nnis_pkg::TEXEL_W-1:0] t,
			pixel_result_t want);
		stim_row_t r;
		r = item_row(o, t);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic logic [nnis_pkg::TEXEL_W-1:0] random_texel();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return nnis_pkg::TEXEL_W'($urandom);
	endfunction

	// size code: zero, over range, maximum or a small size
	function automatic logic [nnis_pkg::CFG_DATA_W-1:0] random_size_code(bit is_dst);
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return nnis_pkg::CFG_DATA_W'(is_dst ? $urandom_range(OUT_DIM + 1, 2047)
				: $urandom_range(TEX_DIM + 1, 2047));
		if (r < 24)
			return nnis_pkg::CFG_DATA_W'(is_dst ? OUT_DIM : TEX_DIM);
		return nnis_pkg::CFG_DATA_W'(is_dst ? $urandom_range(1, 12) : $urandom_range(1, 8));
	endfunction

	// output side idling and the long hold-off
	initial begin
		out_ready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	// compare each pixel with the oldest prediction
	always @(posedge clk) begin : check_pixels
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected pixel: pixel_out %06h col %0d row %0d frame_end %0b",
					pixel_out, dst_col, dst_row, frame_end);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_out !== want.pixel) begin
					$error("pixel_out mismatch: expected %06h, got %06h", want.pixel, pixel_out);
					mismatches++;
				end
				if (dst_col !== want.col) begin
					$error("dst_col mismatch: expected %0d, got %0d", want.col, dst_col);
					mismatches++;
				end
				if (dst_row !== want.row) begin
					$error("dst_row mismatch: expected %0d, got %0d", want.row, dst_row);
					mismatches++;
				end
				if (frame_end !== want.fe) begin
					$error("frame_end mismatch: expected %0b, got %0b", want.fe, frame_end);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stall_count <= 0;
		end else begin
			stall_count <= stall_count + 1;
			if (stall_count >= STALL_LIMIT) begin
				$display("nearest_neighbor_image_scaler verification failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [nnis_pkg::CFG_DATA_W-1:0] sw_code, sh_code, dw_code, dh_code;
		int unsigned swc, shc, total, n_loads, n_mix, random_count;
		logic o;
		bit first_phase;
		stim_row_t r;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = nnis_pkg::OP_LOAD;
		texel_in     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = nnis_pkg::CFG_SRC_WIDTH;
		cfg_data     = '0;
		calm         = 1'b0;
		hold_request = 1'b0;
		hold_served  = 1'b0;
		mismatches   = 0;
		stall_count  = 0;
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// after reset every size is one texel and one pixel
		directed_rows.push_back(item_row(nnis_pkg::OP_LOAD, 24'hFFFFFF));
		directed_rows.push_back(checked_row(nnis_pkg::OP_EMIT, 24'h000000,
			'{pixel: 24'hFFFFFF, col: 10'd0, row: 10'd0, fe: 1'b1}));
		directed_rows.push_back(item_row(nnis_pkg::OP_LOAD, 24'h000000));
		directed_rows.push_back(checked_row(nnis_pkg::OP_EMIT, 24'hFFFFFF,
			'{pixel: 24'h000000, col: 10'd0, row: 10'd0, fe: 1'b1}));
		// zero sizes count as one, over-range sizes saturate
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_SRC_WIDTH, 11'd0));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_SRC_HEIGHT, 11'h7FF));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_WIDTH, 11'h7FF));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_HEIGHT, 11'd0));
		directed_rows.push_back(item_row(nnis_pkg::OP_LOAD, 24'h123456));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'hFFFFFF));
		// shrink leaves the load pointer and column past the new sizes
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_SRC_HEIGHT, 11'd1));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_WIDTH, 11'd2));
		directed_rows.push_back(item_row(nnis_pkg::OP_LOAD, 24'hABCDEF));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));
		directed_rows.push_back(checked_row(nnis_pkg::OP_EMIT, 24'h000000,
			'{pixel: 24'hABCDEF, col: 10'd1, row: 10'd0, fe: 1'b1}));
		// widest texture, tallest destination
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_SRC_WIDTH, 11'd256));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_HEIGHT, 11'd1024));
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_WIDTH, 11'd1));
		directed_rows.push_back(item_row(nnis_pkg::OP_LOAD, 24'h00FF00));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));
		// row counter past the new height restarts
		directed_rows.push_back(cfg_row(nnis_pkg::CFG_DST_HEIGHT, 11'd2));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));
		directed_rows.push_back(item_row(nnis_pkg::OP_EMIT, 24'h000000));

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.kind == ROW_CFG)
				write_reg(r.idx, r.data);
			else
				send_request(r.op, r.texel, r.typed, r.want);
		end

		// random phases: new sizes, a texture load, then mostly emits
		random_count = 0;
		first_phase = 1'b1;
		while (random_count < RANDOM_ITEMS) begin
			if (first_phase) begin
				sw_code = 11'd4;
				sh_code = 11'd4;
				dw_code = 11'd8;
				dh_code = 11'd6;
			end else begin
				sw_code = random_size_code(1'b0);
				sh_code = random_size_code(1'b0);
				dw_code = random_size_code(1'b1);
				dh_code = random_size_code(1'b1);
			end
			swc = fit_size(32'(sw_code[nnis_pkg::SRC_REG_W-1:0]), TEX_DIM);
			shc = fit_size(32'(sh_code[nnis_pkg::SRC_REG_W-1:0]), TEX_DIM);
			// keep the texture small enough to load quickly
			if (swc * shc > 256) begin
				sh_code = nnis_pkg::CFG_DATA_W'($urandom_range(1, 256 / swc));
				shc = 32'(sh_code);
			end
			total = swc * shc;
			write_reg(nnis_pkg::CFG_SRC_WIDTH, sw_code);
			write_reg(nnis_pkg::CFG_SRC_HEIGHT, sh_code);
			write_reg(nnis_pkg::CFG_DST_WIDTH, dw_code);
			write_reg(nnis_pkg::CFG_DST_HEIGHT, dh_code);

			// full texture most of the time, a partial one otherwise
			n_loads = (first_phase || $urandom_range(99) < 70) ? total
				: $urandom_range(0, total);
			repeat (n_loads) begin
				if (random_count >= RANDOM_ITEMS)
					break;
				calm = (random_count >= 300 && random_count < 420);
				send_request(nnis_pkg::OP_LOAD, random_texel(), 1'b0, '0);
				random_count++;
			end

			if (first_phase)
				hold_request = 1'b1;
			n_mix = first_phase ? 60 : $urandom_range(10, 40);
			repeat (n_mix) begin
				if (random_count >= RANDOM_ITEMS)
					break;
				calm = (random_count >= 300 && random_count < 420);
				o = ($urandom_range(99) < 75) ? nnis_pkg::OP_EMIT : nnis_pkg::OP_LOAD;
				// never fetch a texel that was not loaded yet
				if (o == nnis_pkg::OP_EMIT && !written_map[next_fetch_addr()])
					o = nnis_pkg::OP_LOAD;
				send_request(o, random_texel(), 1'b0, '0);
				random_count++;
			end
			first_phase = 1'b0;
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		drain_block();
		if (mismatches == 0)
			$display("nearest_neighbor_image_scaler verification clean");
		else
			$display("nearest_neighbor_image_scaler verification failed");
		$finish;
	end

endmodule

// ===== nearest_neighbor_image_scaler.f =====
design/nnis_pkg.sv
design/nearest_neighbor_image_scaler.sv
bench/tb_nearest_neighbor_image_scaler.sv
